/* hdl/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// Timestamp priority queue package
// Entry and cell control types, command codes and the ordering function
// shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
package tpq_pkg;

   // Channel widths
   localparam int REQ_DATA_WIDTH = 40;
   localparam int REQ_USER_WIDTH = 3;
   localparam int RSP_DATA_WIDTH = 48;
   localparam int RSP_USER_WIDTH = 3;
   localparam int OCC_WIDTH      = 5;

   // Command codes
   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_REPLACE = 2'd1;
   localparam logic [1:0] CMD_REMOVE  = 2'd2;

   // One queued entry
   typedef struct packed {
      logic        kind;   // 0 snapshot, 1 update
      logic [31:0] stamp;
      logic [7:0]  id;
   } entry_type;

   // Per-cycle operation applied to every cell of the chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_REINSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   key;    // entry being placed on insert or reinsert
   } cell_ctrl_type;

   // True when a must sit strictly ahead of b
   function automatic logic entry_before(entry_type a, entry_type b);
      entry_before = (a.stamp < b.stamp) ||
                     ((a.stamp == b.stamp) && (a.kind < b.kind));
   endfunction

endpackage

/* hdl/tpq_cell.sv */
// ----------------------------------------------------------------------------
// Timestamp priority queue cell
// One slot of the sorted chain. Compares the incoming key with its own
// entry and either keeps it, takes the key, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module tpq_cell (
   input  logic                   clock,
   input  tpq_pkg::cell_ctrl_type ctrl,
   input  logic                   at_head,     // first cell of the chain
   input  logic                   slot_valid,  // slot lies below the fill count
   input  logic                   prev_b,      // key goes before the cell towards the head
   input  logic                   next_b,      // key goes before the cell towards the tail
   input  tpq_pkg::entry_type     prev_entry,
   input  tpq_pkg::entry_type     next_entry,
   output logic                   b_out,
   output tpq_pkg::entry_type     entry_out
);
   import tpq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      lower_b;

   // Key goes at or ahead of this slot (an empty slot always qualifies)
   assign b_out = !slot_valid || entry_before(ctrl.key, entry_ff);

   // After a head removal the chain is shifted by one; the head has no lower slot
   assign lower_b = b_out && !at_head;

   // Next slot contents
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (prev_b) begin
               entry_in = prev_entry;
            end else if (b_out) begin
               entry_in = ctrl.key;
            end
         end
         OP_REMOVE: begin
            entry_in = next_entry;
         end
         OP_REINSERT: begin
            if (lower_b) begin
               entry_in = entry_ff;
            end else if (next_b) begin
               entry_in = ctrl.key;
            end else begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

/* hdl/timestamp_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// Timestamp priority queue
// Bounded queue of source identifiers kept sorted by time, snapshot before
// update on equal time, arrival order otherwise. Built as a chain of cells.
//
//   Channel | Dir | Transfer carries
//   req_    | in  | command, entry id, time, type
//   rsp_    | out | head entry, occupancy, rejected flag
//
// All cells compare against the key in parallel and shift on the same edge,
// so one transfer per cycle is taken while the response is not stalled.
// The response is registered and appears in the cycle after its command.
// A stalled response holds req_tready low until it is taken.
// Synchronous active-high reset empties the queue; slots need no clearing.
// ----------------------------------------------------------------------------
module timestamp_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tpq_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // entry_id, entry_time
   input  logic [tpq_pkg::REQ_USER_WIDTH-1:0]  req_tuser,  // cmd, entry_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpq_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // head_id, head_time, occupancy
   output logic [tpq_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser   // head_valid, head_type, rejected
);
   import tpq_pkg::*;

   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rejected_ff, rejected_in;

   entry_type     cell_entry [QUEUE_DEPTH];
   logic          cell_b     [QUEUE_DEPTH];
   cell_ctrl_type ctrl;
   entry_type     req_entry;
   entry_type     head;
   logic [1:0]    req_cmd;
   logic          accept;
   logic          empty;
   logic          full;

   // Request decode
   assign req_cmd         = req_tuser[1:0];
   assign req_entry.id    = req_tdata[7:0];
   assign req_entry.stamp = req_tdata[39:8];
   assign req_entry.kind  = req_tuser[2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CountWidth'(QUEUE_DEPTH));

   // Command decode into a chain operation
   always_comb begin
      ctrl.op     = OP_HOLD;
      ctrl.key    = req_entry;
      count_in    = count_ff;
      rejected_in = rejected_ff;
      if (accept) begin
         rejected_in = 1'b0;
         case (req_cmd)
            CMD_INSERT: begin
               if (full) begin
                  rejected_in = 1'b1;
               end else begin
                  ctrl.op  = OP_INSERT;
                  count_in = count_ff + CountWidth'(1);
               end
            end
            CMD_REPLACE: begin
               if (empty) begin
                  rejected_in = 1'b1;
               end else if (cell_entry[0].stamp != req_entry.stamp) begin
                  ctrl.op        = OP_REINSERT;
                  ctrl.key.id    = cell_entry[0].id;
                  ctrl.key.kind  = cell_entry[0].kind;
               end
            end
            CMD_REMOVE: begin
               if (empty) begin
                  rejected_in = 1'b1;
               end else begin
                  ctrl.op  = OP_REMOVE;
                  count_in = count_ff - CountWidth'(1);
               end
            end
            default: begin
               rejected_in = 1'b0;
            end
         endcase
      end
   end

   // Response valid: set by a transfer in, cleared when taken
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rejected_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rejected_ff  <= rejected_in;
      end
   end

   // Cell chain, head at index 0
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic      prev_b, next_b;
      entry_type prev_entry, next_entry;

      if (g == 0) begin : g_first
         assign prev_b     = 1'b0;
         assign prev_entry = '0;
      end else begin : g_mid_lo
         assign prev_b     = cell_b[g-1];
         assign prev_entry = cell_entry[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign next_b     = 1'b1;
         assign next_entry = '0;
      end else begin : g_mid_hi
         assign next_b     = cell_b[g+1];
         assign next_entry = cell_entry[g+1];
      end

      tpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .at_head    (g == 0),
         .slot_valid (count_ff > CountWidth'(g)),
         .prev_b     (prev_b),
         .next_b     (next_b),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .b_out      (cell_b[g]),
         .entry_out  (cell_entry[g])
      );
   end

   // Response formatting; head reads as zero when empty
   assign head       = empty ? '0 : cell_entry[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, OCC_WIDTH'(count_ff), head.stamp, head.id};
   assign rsp_tuser  = {rejected_ff, head.kind, !empty};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CountWidth'(2)) |-> !entry_before(cell_entry[1], cell_entry[0]))
      else $error("head and second entry out of order");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_INSERT && full) |=> (rejected_ff && full))
      else $error("insert into full queue not refused");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_REMOVE && !empty) |=>
         (count_ff == $past(count_ff) - CountWidth'(1) && !rejected_ff))
      else $error("remove did not drop one entry");

endmodule
